// ----- design/ptf_pkg.sv -----
// Shared types, constants and helpers for the transition firing block.
package ptf_pkg;

  localparam int PLACE_COUNT    = 8;
  localparam int PAIR_COUNT_MAX = 3;
  localparam int TOKEN_BITS     = 16;
  localparam int REG_PAIRS      = 3;
  localparam int MASK_BITS      = 8;
  localparam int PAIR_LIMIT     = (PAIR_COUNT_MAX < REG_PAIRS) ? PAIR_COUNT_MAX : REG_PAIRS;
  localparam int PLACE_IDX_W    = (PLACE_COUNT > 1) ? $clog2(PLACE_COUNT) : 1;
  localparam int ADDR_W         = 5;

  localparam logic [1:0] MODE_FIRE = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [2:0] REG_PAIR_COUNT    = 3'd0;
  localparam logic [2:0] REG_INPUT_MASK_A  = 3'd1;
  localparam logic [2:0] REG_OUTPUT_MASK_A = 3'd2;
  localparam logic [2:0] REG_INPUT_MASK_B  = 3'd3;
  localparam logic [2:0] REG_OUTPUT_MASK_B = 3'd4;
  localparam logic [2:0] REG_INPUT_MASK_C  = 3'd5;
  localparam logic [2:0] REG_OUTPUT_MASK_C = 3'd6;

  typedef logic [TOKEN_BITS-1:0] count_t;
  typedef count_t [PLACE_COUNT-1:0] counts_t;
  typedef logic [MASK_BITS-1:0] mask_t;

  typedef struct packed {
    logic [1:0]                pair_count;
    mask_t [REG_PAIRS-1:0]     in_mask;
    mask_t [REG_PAIRS-1:0]     out_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  place;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [1:0]  fired_pair;
    logic [15:0] read_value;
  } out_item_t;

  function automatic logic mask_bit(input mask_t m, input int p);
    logic b;
    b = 1'b0;
    if (p < MASK_BITS) begin
      b = m[p];
    end
    return b;
  endfunction

endpackage

// ----- design/ptf_fire.sv -----
// Firing, load and read logic for one item against the token counts.
module ptf_fire import ptf_pkg::*; (
  input  counts_t   counts,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output counts_t   counts_next,
  output out_item_t result
);

  localparam count_t TOKEN_MAX = '1;

  logic [REG_PAIRS-1:0] live;
  logic [REG_PAIRS-1:0] enable;
  mask_t                has_token;
  logic                 hit;
  logic [1:0]           hit_pair;
  mask_t                sel_in;
  mask_t                sel_out;
  counts_t              fire_counts;
  count_t               bumped;
  logic                 place_ok;
  logic [PLACE_IDX_W-1:0] place_idx;

  always_comb begin
    has_token = '1;
    for (int p = 0; p < MASK_BITS; p++) begin
      if (p < PLACE_COUNT) begin
        has_token[p] = (counts[p] != '0);
      end
    end
    for (int k = 0; k < REG_PAIRS; k++) begin
      live[k]   = (k < PAIR_LIMIT) && (2'(k) < cfg.pair_count);
      enable[k] = live[k] && ((cfg.in_mask[k] & ~has_token) == '0);
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_pair = '0;
    sel_in   = '0;
    sel_out  = '0;
    for (int k = 0; k < REG_PAIRS; k++) begin
      if (enable[k] && !hit) begin
        hit      = 1'b1;
        hit_pair = 2'(k);
        sel_in   = cfg.in_mask[k];
        sel_out  = cfg.out_mask[k];
      end
    end
  end

  always_comb begin
    fire_counts = counts;
    bumped      = '0;
    for (int p = 0; p < PLACE_COUNT; p++) begin
      bumped = counts[p];
      if (mask_bit(sel_out, p) && bumped != TOKEN_MAX) begin
        bumped = bumped + count_t'(1);
      end
      if (mask_bit(sel_in, p) && bumped != '0) begin
        bumped = bumped - count_t'(1);
      end
      fire_counts[p] = bumped;
    end
  end

  assign place_ok  = (32'(item.place) < PLACE_COUNT);
  assign place_idx = PLACE_IDX_W'(item.place);

  always_comb begin
    counts_next = counts;
    result      = '0;
    unique case (item.mode)
      MODE_FIRE: begin
        if (live == '0) begin
          result.status = 1'b1;
        end else if (hit) begin
          result.fired      = 1'b1;
          result.fired_pair = hit_pair;
          counts_next       = fire_counts;
        end
      end
      MODE_LOAD: begin
        if (place_ok) begin
          counts_next[place_idx] = count_t'(item.value);
        end
      end
      MODE_READ: begin
        if (place_ok) begin
          result.read_value = 16'(counts[place_idx]);
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// ----- design/petri_transition_fire_top.sv -----
// Top level: Petri-net token counts with transition firing, load and read.
// Structure: input register, firing logic, result register; the result is registered.
// Throughput: one item per cycle while the output is not stalled; the firing logic sits between
// the two registers and the token counts update at the edge that loads the result register.
// Reset: synchronous, active high; clears token counts, configuration registers and both valids.
module petri_transition_fire_top import ptf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  counts_t   tokens;
  counts_t   tokens_next;
  logic      s1_valid;
  in_item_t  s1_item;
  out_item_t result;
  logic      advance;
  logic      cfg_write;
  logic [2:0] reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PAIR_COUNT:    cfg.pair_count  <= pwdata[1:0];
        REG_INPUT_MASK_A:  cfg.in_mask[0]  <= pwdata[7:0];
        REG_OUTPUT_MASK_A: cfg.out_mask[0] <= pwdata[7:0];
        REG_INPUT_MASK_B:  cfg.in_mask[1]  <= pwdata[7:0];
        REG_OUTPUT_MASK_B: cfg.out_mask[1] <= pwdata[7:0];
        REG_INPUT_MASK_C:  cfg.in_mask[2]  <= pwdata[7:0];
        REG_OUTPUT_MASK_C: cfg.out_mask[2] <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAIR_COUNT:    prdata = 32'(cfg.pair_count);
      REG_INPUT_MASK_A:  prdata = 32'(cfg.in_mask[0]);
      REG_OUTPUT_MASK_A: prdata = 32'(cfg.out_mask[0]);
      REG_INPUT_MASK_B:  prdata = 32'(cfg.in_mask[1]);
      REG_OUTPUT_MASK_B: prdata = 32'(cfg.out_mask[1]);
      REG_INPUT_MASK_C:  prdata = 32'(cfg.in_mask[2]);
      REG_OUTPUT_MASK_C: prdata = 32'(cfg.out_mask[2]);
      default:           prdata = '0;
    endcase
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  ptf_fire u_fire (
    .counts      (tokens),
    .cfg         (cfg),
    .item        (s1_item),
    .counts_next (tokens_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tokens <= '0;
    end else if (s1_valid && advance) begin
      tokens <= tokens_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data <= result;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held item");

  a_item_moves_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("item left the input register but no result appeared");

  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.status && out_data.fired))
    else $error("empty-transition status together with a fire");

  a_pair_in_use: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.fired) |-> (out_data.fired_pair < cfg.pair_count))
    else $error("fired pair beyond the pairs in use");

endmodule

// ----- tb/sv/petri_fire_checker.sv -----
// Checker for the transition firing block: token-count predictor and result scoreboard.
`timescale 1ns / 1ps

module petri_fire_checker import ptf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fails,
  output int                pending
);

  counts_t   tokens;
  cfg_t      transition;
  out_item_t expected_results[$];
  out_item_t want;
  int        mismatches = 0;

  assign fails = mismatches;

  function automatic logic pair_enabled(mask_t m);
    logic ok;
    ok = 1'b1;
    for (int p = 0; p < PLACE_COUNT; p++) begin
      if (m[p] && tokens[p] == '0) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic int cfg_pairs();
    return int'(transition.pair_count);
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    int        n;
    logic      hit;
    r   = '0;
    hit = 1'b0;
    case (it.mode)
      MODE_FIRE: begin
        n = (cfg_pairs() > PAIR_LIMIT) ? PAIR_LIMIT : cfg_pairs();
        if (n == 0) begin
          r.status = 1'b1;
        end else begin
          for (int k = 0; k < n && !hit; k++) begin
            if (pair_enabled(transition.in_mask[k])) begin
              for (int p = 0; p < PLACE_COUNT; p++) begin
                if (transition.out_mask[k][p] && tokens[p] != '1) begin
                  tokens[p] = tokens[p] + 1'b1;
                end
              end
              for (int p = 0; p < PLACE_COUNT; p++) begin
                if (transition.in_mask[k][p] && tokens[p] != '0) begin
                  tokens[p] = tokens[p] - 1'b1;
                end
              end
              hit          = 1'b1;
              r.fired      = 1'b1;
              r.fired_pair = 2'(k);
            end
          end
        end
      end
      MODE_LOAD: tokens[it.place] = it.value;
      MODE_READ: r.read_value = tokens[it.place];
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tokens     = '0;
      transition = '0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: %p", out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.fired !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, out_data.fired);
            mismatches++;
          end
          if (out_data.fired_pair !== want.fired_pair) begin
            $error("fired_pair: expected %0d, got %0d", want.fired_pair, out_data.fired_pair);
            mismatches++;
          end
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PAIR_COUNT:    transition.pair_count  = pwdata[1:0];
          REG_INPUT_MASK_A:  transition.in_mask[0]  = pwdata[MASK_BITS-1:0];
          REG_OUTPUT_MASK_A: transition.out_mask[0] = pwdata[MASK_BITS-1:0];
          REG_INPUT_MASK_B:  transition.in_mask[1]  = pwdata[MASK_BITS-1:0];
          REG_OUTPUT_MASK_B: transition.out_mask[1] = pwdata[MASK_BITS-1:0];
          REG_INPUT_MASK_C:  transition.in_mask[2]  = pwdata[MASK_BITS-1:0];
          REG_OUTPUT_MASK_C: transition.out_mask[2] = pwdata[MASK_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), apply_item(in_data));
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ----- tb/sv/tb_petri_transition_fire_top.sv -----
// Testbench top for the transition firing block: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_petri_transition_fire_top import ptf_pkg::*;;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         PHASES      = 12;
  localparam int         PHASE_ITEMS = 128;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fails;
  int pending;
  int cycles = 0;
  bit quiet  = 1'b0;

  petri_transition_fire_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  petri_fire_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 25);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] m, logic [2:0] p, logic [15:0] v);
    in_item_t it;
    it.mode  = m;
    it.place = p;
    it.value = v;
    return it;
  endfunction

  function automatic mask_t sparse_mask();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return mask_t'($urandom);
    return mask_t'($urandom & $urandom);
  endfunction

  function automatic in_item_t random_item();
    int          r;
    int          s;
    logic [15:0] v;
    logic [1:0]  m;
    r = $urandom_range(99);
    s = $urandom_range(9);
    v = 16'($urandom);
    if (r < 45) begin
      m = MODE_FIRE;
    end else if (r < 70) begin
      m = MODE_LOAD;
      if (s < 6) v = 16'($urandom_range(3));
      else if (s == 6) v = 16'hFFFF;
      else if (s == 7) v = 16'hFFFE;
    end else if (r < 95) begin
      m = MODE_READ;
    end else begin
      m = MODE_UNUSED;
    end
    return make_item(m, 3'($urandom_range(7)), v);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_transition(logic [1:0] pc, mask_t ia, mask_t oa, mask_t ib,
                                    mask_t ob, mask_t ic, mask_t oc);
    write_reg(REG_PAIR_COUNT, 32'(pc));
    write_reg(REG_INPUT_MASK_A, 32'(ia));
    write_reg(REG_OUTPUT_MASK_A, 32'(oa));
    write_reg(REG_INPUT_MASK_B, 32'(ib));
    write_reg(REG_OUTPUT_MASK_B, 32'(ob));
    write_reg(REG_INPUT_MASK_C, 32'(ic));
    write_reg(REG_OUTPUT_MASK_C, 32'(oc));
  endtask

  task automatic send_item(in_item_t it);
    while (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty transition, load and read extremes, unused mode
    send_item(make_item(MODE_FIRE, 3'd0, 16'hFFFF));
    send_item(make_item(MODE_READ, 3'd0, 16'h0000));
    send_item(make_item(MODE_LOAD, 3'd0, 16'hFFFF));
    send_item(make_item(MODE_LOAD, 3'd7, 16'h0000));
    send_item(make_item(MODE_LOAD, 3'd3, 16'h0001));
    send_item(make_item(MODE_READ, 3'd0, 16'hFFFF));
    send_item(make_item(MODE_UNUSED, 3'd7, 16'hFFFF));
    send_item(make_item(MODE_READ, 3'd3, 16'h0000));
    drain();

    // pair a blocked, pair b self-loop at saturation, pair c with empty input mask
    program_transition(2'd3, 8'h80, 8'h01, 8'h01, 8'h01, 8'h00, 8'hFF);
    send_item(make_item(MODE_FIRE, 3'd0, 16'h0000));
    send_item(make_item(MODE_READ, 3'd0, 16'h0000));
    send_item(make_item(MODE_LOAD, 3'd0, 16'h0000));
    send_item(make_item(MODE_FIRE, 3'd0, 16'h0000));
    send_item(make_item(MODE_READ, 3'd7, 16'h0000));
    send_item(make_item(MODE_FIRE, 3'd0, 16'h0000));
    send_item(make_item(MODE_READ, 3'd0, 16'h0000));
    send_item(make_item(MODE_READ, 3'd7, 16'h0000));
    drain();

    // no pair enabled with one pair in use, then pair a still blocked with two pairs in use
    program_transition(2'd1, 8'h80, 8'h01, 8'h02, 8'h04, 8'h00, 8'h00);
    send_item(make_item(MODE_FIRE, 3'd0, 16'h0000));
    send_item(make_item(MODE_READ, 3'd7, 16'h0000));
    drain();
    program_transition(2'd2, 8'h80, 8'h01, 8'h02, 8'h04, 8'h00, 8'h00);
    send_item(make_item(MODE_FIRE, 3'd0, 16'h0000));
    send_item(make_item(MODE_READ, 3'd2, 16'h0000));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       program_transition(2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1:       program_transition(2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        5:       program_transition(2'd3, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        default: program_transition(2'(ph), sparse_mask(), sparse_mask(), sparse_mask(),
                                    sparse_mask(), sparse_mask(), sparse_mask());
      endcase
      quiet = (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_item());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
